// ===== hdl/ax25_pkg.sv =====
`timescale 1ns / 1ps

package ax25_pkg;

    typedef struct packed {
        logic [7:0] info_byte;
        logic       frame_start;
        logic       frame_end;
        logic       byte_valid;
    } info_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } frame_t;

    localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [15:0] CRC_PRESET = 16'hFFFF;

    localparam logic [55:0] DEST_RESET = 56'h4E4F43414C4C60;
    localparam logic [55:0] SRC_RESET  = 56'h4E4F43414C4C62;
    localparam logic [7:0]  CTRL_RESET = 8'h03;
    localparam logic [7:0]  PID_RESET  = 8'hF0;

    localparam int          ADDR_W   = 5;
    localparam logic [1:0]  REG_DEST = 2'd0;
    localparam logic [1:0]  REG_SRC  = 2'd1;
    localparam logic [1:0]  REG_CTRL = 2'd2;
    localparam logic [1:0]  REG_PID  = 2'd3;

    // byte positions within one word's run of output bytes
    localparam int          STEP_W          = 5;
    localparam logic [4:0]  STEP_FLAG_OPEN  = 5'd0;
    localparam logic [4:0]  STEP_DEST_FIRST = 5'd1;
    localparam logic [4:0]  STEP_DEST_LAST  = 5'd7;
    localparam logic [4:0]  STEP_SRC_FIRST  = 5'd8;
    localparam logic [4:0]  STEP_SRC_LAST   = 5'd14;
    localparam logic [4:0]  STEP_CTRL       = 5'd15;
    localparam logic [4:0]  STEP_PID        = 5'd16;
    localparam logic [4:0]  STEP_INFO       = 5'd17;
    localparam logic [4:0]  STEP_FCS_LO     = 5'd18;
    localparam logic [4:0]  STEP_FCS_HI     = 5'd19;
    localparam logic [4:0]  STEP_FLAG_CLOSE = 5'd20;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/ax25_ui_frame_builder.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake                  Word
// info      in   info_valid / info_ready    ax25_pkg::info_t
// frame     out  frame_valid / frame_ready  ax25_pkg::frame_t
// apb       in   psel / penable / pready    64-bit registers at 8*i
//
// One output byte per cycle while frame_ready keeps the output register
// draining; a word causes up to 21 bytes. The next word is taken in
// the cycle its predecessor's last byte enters the output register.
// The output register holds its byte while frame_ready is low; the byte
// sequencer then stalls. Reset clears the frame, presets CRC and registers.
module ax25_ui_frame_builder
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ax25_pkg::ADDR_W-1:0]        paddr,
    input  logic [63:0]                        pwdata,
    output logic [63:0]                        prdata,
    output logic                               pready,
    input  logic                               info_valid,
    output logic                               info_ready,
    input  ax25_pkg::info_t                    info,
    output logic                               frame_valid,
    input  logic                               frame_ready,
    output ax25_pkg::frame_t                   frame
);

    logic [55:0] dest_reg;
    logic [55:0] src_reg;
    logic [7:0]  ctrl_reg;
    logic [7:0]  pid_reg;
    logic [1:0]  reg_idx;
    logic        cfg_wr;

    ax25_pkg::info_t             item_reg;
    logic                        item_vld_reg;
    logic                        started_reg;
    logic [ax25_pkg::STEP_W-1:0] step_reg;
    logic [ax25_pkg::STEP_W-1:0] step_next;
    logic [15:0]                 crc_reg;
    logic [15:0]                 crc_next;
    logic                        in_frame_reg;
    logic                        in_frame_next;
    logic                        out_valid_reg;
    ax25_pkg::frame_t            out_reg;

    logic                        info_en;
    logic                        end_en;
    logic                        first_vld;
    logic [ax25_pkg::STEP_W-1:0] first_step;
    logic                        cur_vld;
    logic [ax25_pkg::STEP_W-1:0] cur_step;
    logic                        nxt_vld;
    logic [ax25_pkg::STEP_W-1:0] nxt_step;
    logic [2:0]                  byte_idx;
    logic [7:0]                  cur_byte;
    logic                        crc_en;
    logic [15:0]                 fcs;
    logic                        fire;
    logic                        item_done;
    logic                        accept;

    assign reg_idx = paddr[ax25_pkg::ADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        case (reg_idx)
            ax25_pkg::REG_DEST: prdata = {8'h00, dest_reg};
            ax25_pkg::REG_SRC:  prdata = {8'h00, src_reg};
            ax25_pkg::REG_CTRL: prdata = {56'h0, ctrl_reg};
            ax25_pkg::REG_PID:  prdata = {56'h0, pid_reg};
            default:            prdata = 64'h0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_reg <= ax25_pkg::DEST_RESET;
            src_reg  <= ax25_pkg::SRC_RESET;
            ctrl_reg <= ax25_pkg::CTRL_RESET;
            pid_reg  <= ax25_pkg::PID_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                ax25_pkg::REG_DEST: dest_reg <= pwdata[55:0];
                ax25_pkg::REG_SRC:  src_reg  <= pwdata[55:0];
                ax25_pkg::REG_CTRL: ctrl_reg <= pwdata[7:0];
                ax25_pkg::REG_PID:  pid_reg  <= pwdata[7:0];
                default:            ;
            endcase
        end
    end

    // which parts of the run this word owns
    assign info_en = item_reg.byte_valid && (item_reg.frame_start || in_frame_reg);
    assign end_en  = item_reg.frame_end && (item_reg.frame_start || in_frame_reg);

    always_comb
    begin
        first_vld  = 1'b1;
        first_step = ax25_pkg::STEP_FLAG_OPEN;
        if (item_reg.frame_start)
        begin
            first_step = ax25_pkg::STEP_FLAG_OPEN;
        end
        else if (info_en)
        begin
            first_step = ax25_pkg::STEP_INFO;
        end
        else if (end_en)
        begin
            first_step = ax25_pkg::STEP_FCS_LO;
        end
        else
        begin
            first_vld = 1'b0;
        end
    end

    assign cur_vld  = started_reg ? 1'b1 : first_vld;
    assign cur_step = started_reg ? step_reg : first_step;

    always_comb
    begin
        nxt_vld  = 1'b0;
        nxt_step = cur_step + 5'd1;
        case (cur_step) inside
            [ax25_pkg::STEP_FLAG_OPEN:ax25_pkg::STEP_CTRL]:
            begin
                nxt_vld = 1'b1;
            end
            ax25_pkg::STEP_PID:
            begin
                if (info_en)
                begin
                    nxt_vld  = 1'b1;
                    nxt_step = ax25_pkg::STEP_INFO;
                end
                else if (end_en)
                begin
                    nxt_vld  = 1'b1;
                    nxt_step = ax25_pkg::STEP_FCS_LO;
                end
            end
            ax25_pkg::STEP_INFO:
            begin
                nxt_vld  = end_en;
                nxt_step = ax25_pkg::STEP_FCS_LO;
            end
            ax25_pkg::STEP_FCS_LO, ax25_pkg::STEP_FCS_HI:
            begin
                nxt_vld = 1'b1;
            end
            default:
            begin
                nxt_vld = 1'b0;
            end
        endcase
    end

    assign fcs = ~crc_reg;

    always_comb
    begin
        byte_idx = 3'd0;
        crc_en   = 1'b0;
        cur_byte = ax25_pkg::FLAG_BYTE;
        case (cur_step) inside
            [ax25_pkg::STEP_DEST_FIRST:ax25_pkg::STEP_DEST_LAST]:
            begin
                byte_idx = 3'(ax25_pkg::STEP_DEST_LAST - cur_step);
                cur_byte = 8'(dest_reg >> {byte_idx, 3'b000});
                crc_en   = 1'b1;
            end
            [ax25_pkg::STEP_SRC_FIRST:ax25_pkg::STEP_SRC_LAST]:
            begin
                byte_idx = 3'(ax25_pkg::STEP_SRC_LAST - cur_step);
                cur_byte = 8'(src_reg >> {byte_idx, 3'b000});
                crc_en   = 1'b1;
            end
            ax25_pkg::STEP_CTRL:
            begin
                cur_byte = ctrl_reg;
                crc_en   = 1'b1;
            end
            ax25_pkg::STEP_PID:
            begin
                cur_byte = pid_reg;
                crc_en   = 1'b1;
            end
            ax25_pkg::STEP_INFO:
            begin
                cur_byte = item_reg.info_byte;
                crc_en   = 1'b1;
            end
            ax25_pkg::STEP_FCS_LO: cur_byte = fcs[7:0];
            ax25_pkg::STEP_FCS_HI: cur_byte = fcs[15:8];
            default:               cur_byte = ax25_pkg::FLAG_BYTE;
        endcase
    end

    assign fire       = item_vld_reg && cur_vld && (!out_valid_reg || frame_ready);
    assign item_done  = item_vld_reg && (!cur_vld || (fire && !nxt_vld));
    assign info_ready = !item_vld_reg || item_done;
    assign accept     = info_valid && info_ready;

    always_comb
    begin
        crc_next      = crc_reg;
        in_frame_next = in_frame_reg;
        step_next     = step_reg;
        if (fire)
        begin
            step_next = nxt_step;
            if (cur_step == ax25_pkg::STEP_FLAG_OPEN)
            begin
                crc_next      = ax25_pkg::CRC_PRESET;
                in_frame_next = 1'b1;
            end
            else if (cur_step == ax25_pkg::STEP_FLAG_CLOSE)
            begin
                crc_next      = ax25_pkg::CRC_PRESET;
                in_frame_next = 1'b0;
            end
            else if (crc_en)
            begin
                crc_next = ax25_pkg::crc_byte(crc_reg, cur_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg  <= 1'b0;
            started_reg   <= 1'b0;
            step_reg      <= ax25_pkg::STEP_FLAG_OPEN;
            crc_reg       <= ax25_pkg::CRC_PRESET;
            in_frame_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg      <= crc_next;
            in_frame_reg <= in_frame_next;
            step_reg     <= step_next;
            if (accept)
            begin
                item_vld_reg <= 1'b1;
                started_reg  <= 1'b0;
            end
            else if (item_done)
            begin
                item_vld_reg <= 1'b0;
                started_reg  <= 1'b0;
            end
            else if (fire)
            begin
                started_reg <= 1'b1;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (frame_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= info;
        end
        if (fire)
        begin
            out_reg.out_byte <= cur_byte;
            out_reg.run_last <= !nxt_vld;
        end
    end

    assign frame_valid = out_valid_reg;
    assign frame       = out_reg;

    // FCS bytes only go out inside an open frame
    a_fcs_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cur_step == ax25_pkg::STEP_FCS_LO) |-> in_frame_reg)
        else $error("FCS emitted with no frame open");

    // closing flag leaves the CRC preset and the frame closed
    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cur_step == ax25_pkg::STEP_FLAG_CLOSE)
        |=> (crc_reg == ax25_pkg::CRC_PRESET && !in_frame_reg))
        else $error("frame state not cleared after closing flag");

    // a running sequence never walks past the closing flag
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (item_vld_reg && started_reg) |-> (step_reg <= ax25_pkg::STEP_FLAG_CLOSE))
        else $error("byte step out of range");

    // a new word is only taken once the previous one is finished
    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item_vld_reg) |-> item_done)
        else $error("word accepted over an unfinished one");

    // an opening flag is the first byte of its word's run
    a_open_first: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cur_step == ax25_pkg::STEP_FLAG_OPEN) |-> !started_reg)
        else $error("opening flag in the middle of a run");

endmodule

// ===== tb/tb_ax25_ui_frame_builder.sv =====
`timescale 1ns / 1ps

module tb_ax25_ui_frame_builder;

    localparam int DRAIN_WAIT     = 25;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int WORDS_PER_RUN  = 45;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ax25_pkg::ADDR_W-1:0] paddr;
    logic [63:0]                 pwdata;
    logic [63:0]                 prdata;
    logic                        pready;
    logic                        info_valid;
    logic                        info_ready;
    ax25_pkg::info_t             info;
    logic                        frame_valid;
    logic                        frame_ready;
    ax25_pkg::frame_t            frame;

    // local copy of the framing state and registers
    logic [55:0]         dest_copy;
    logic [55:0]         src_copy;
    logic [7:0]          ctrl_copy;
    logic [7:0]          pid_copy;
    logic [15:0]         running_crc;
    logic                frame_open;

    logic [7:0]          burst[$];
    ax25_pkg::frame_t    expected_bytes[$];
    ax25_pkg::frame_t    oldest_byte;

    int                  fail_count;
    int                  words_counted;
    int                  quiet_cycles;
    int                  rx_stall;
    bit                  rx_took;
    bit                  burst_mode;
    bit                  pause_pending;

    ax25_ui_frame_builder dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .info_valid  (info_valid),
        .info_ready  (info_ready),
        .info        (info),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [15:0] crc_shift_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = r[0] ^ b[i];
            r  = r >> 1;
            if (fb)
            begin
                r = r ^ ax25_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic void emit_byte(input logic [7:0] b, input bit covered);
        if (covered)
        begin
            running_crc = crc_shift_byte(running_crc, b);
        end
        burst.push_back(b);
    endfunction

    function automatic int predict_frame_bytes(input ax25_pkg::info_t w);
        logic [15:0]      fcs;
        ax25_pkg::frame_t fb;
        burst.delete();
        if (w.frame_start)
        begin
            running_crc = ax25_pkg::CRC_PRESET;
            frame_open  = 1'b1;
            emit_byte(ax25_pkg::FLAG_BYTE, 1'b0);
            for (int k = 6; k >= 0; k--)
            begin
                emit_byte(dest_copy[8*k +: 8], 1'b1);
            end
            for (int k = 6; k >= 0; k--)
            begin
                emit_byte(src_copy[8*k +: 8], 1'b1);
            end
            emit_byte(ctrl_copy, 1'b1);
            emit_byte(pid_copy, 1'b1);
        end
        if (frame_open && w.byte_valid)
        begin
            emit_byte(w.info_byte, 1'b1);
        end
        if (frame_open && w.frame_end)
        begin
            fcs = ~running_crc;
            emit_byte(fcs[7:0], 1'b0);
            emit_byte(fcs[15:8], 1'b0);
            emit_byte(ax25_pkg::FLAG_BYTE, 1'b0);
            running_crc = ax25_pkg::CRC_PRESET;
            frame_open  = 1'b0;
        end
        foreach (burst[i])
        begin
            fb.out_byte = burst[i];
            fb.run_last = (i == burst.size() - 1);
            expected_bytes.push_back(fb);
        end
        return burst.size();
    endfunction

    task automatic send_word(input logic [7:0] b, input bit s, input bit e, input bit v);
        int              gap;
        bit              took;
        ax25_pkg::info_t w;
        w.info_byte   = b;
        w.frame_start = s;
        w.frame_end   = e;
        w.byte_valid  = v;
        gap = burst_mode ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            info_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        info       <= w;
        info_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            took = info_valid && info_ready;
            @(posedge clk);
        end
        while (!took);
        if (predict_frame_bytes(w) > 0)
        begin
            words_counted++;
        end
    endtask

    task automatic wait_drained();
        info_valid <= 1'b0;
        while (expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
        end
        while (!pready);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ax25_pkg::REG_DEST: dest_copy = value[55:0];
            ax25_pkg::REG_SRC:  src_copy  = value[55:0];
            ax25_pkg::REG_CTRL: ctrl_copy = value[7:0];
            ax25_pkg::REG_PID:  pid_copy  = value[7:0];
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [63:0] d, input logic [63:0] s,
                                  input logic [63:0] c, input logic [63:0] p);
        settle();
        write_reg(ax25_pkg::REG_DEST, d);
        write_reg(ax25_pkg::REG_SRC, s);
        write_reg(ax25_pkg::REG_CTRL, c);
        write_reg(ax25_pkg::REG_PID, p);
    endtask

    task automatic test_reset_defaults();
        send_word(8'h00, 1'b1, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b0, 1'b1);
        send_word(8'hFF, 1'b0, 1'b1, 1'b1);
    endtask

    task automatic test_corner_cases();
        // stray words with no frame open
        send_word(8'hA5, 1'b0, 1'b0, 1'b1);
        send_word(8'h5A, 1'b0, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b0, 1'b0);
        // whole frame in one word
        send_word(8'hC3, 1'b1, 1'b1, 1'b1);
        // restart drops the open frame
        send_word(8'h5A, 1'b1, 1'b0, 1'b1);
        send_word(8'hA5, 1'b0, 1'b0, 1'b1);
        send_word(8'h3C, 1'b1, 1'b0, 1'b1);
        send_word(8'h81, 1'b0, 1'b0, 1'b0);
        send_word(8'h7E, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_register_extremes();
        write_all_regs(64'h0, 64'h0, 64'h0, 64'h0);
        send_word(8'hFF, 1'b1, 1'b1, 1'b1);
        write_all_regs('1, '1, '1, '1);
        send_word(8'h00, 1'b1, 1'b1, 1'b1);
        send_word(8'h42, 1'b1, 1'b1, 1'b0);
    endtask

    task automatic random_frames(input int target);
        int kind;
        int len;
        words_counted = 0;
        pause_pending = 1'b1;
        while (words_counted < target)
        begin
            burst_mode = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 9);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 6);
            if (kind < 8)
            begin
                if (len == 0)
                begin
                    if ($urandom_range(0, 1))
                    begin
                        send_word(8'($urandom), 1'b1, 1'b1, 1'b0);
                    end
                    else
                    begin
                        send_word(8'($urandom), 1'b1, 1'b0, 1'b0);
                        send_word(8'($urandom), 1'b0, 1'b1, 1'b0);
                    end
                end
                for (int i = 0; i < len; i++)
                begin
                    if (i > 0 && $urandom_range(0, 7) == 0)
                    begin
                        send_word(8'($urandom), 1'b0, 1'b0, 1'b0);
                    end
                    if (i == 1 && pause_pending)
                    begin
                        wait_drained();
                        pause_pending = 1'b0;
                    end
                    send_word(8'($urandom), i == 0, i == len - 1, 1'b1);
                end
            end
            else if (kind == 8)
            begin
                send_word(8'($urandom), 1'b1, 1'b0, 1'($urandom_range(0, 1)));
                for (int i = 0; i < len; i++)
                begin
                    send_word(8'($urandom), 1'b0, 1'b0, 1'b1);
                end
            end
            else
            begin
                send_word(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
        end
        burst_mode = 1'b0;
    endtask

    task automatic test_random_traffic();
        write_all_regs({$urandom, $urandom}, {$urandom, $urandom},
                       64'($urandom), 64'($urandom));
        random_frames(WORDS_PER_RUN);
        write_all_regs(64'(ax25_pkg::DEST_RESET), 64'(ax25_pkg::SRC_RESET),
                       64'(ax25_pkg::CTRL_RESET), 64'(ax25_pkg::PID_RESET));
        random_frames(WORDS_PER_RUN);
        write_all_regs({$urandom, $urandom}, {$urandom, $urandom},
                       64'($urandom), 64'($urandom));
        random_frames(WORDS_PER_RUN);
        write_all_regs({$urandom, $urandom}, {$urandom, $urandom},
                       64'($urandom), 64'($urandom));
        random_frames(WORDS_PER_RUN);
    endtask

    always
    begin
        rx_stall = burst_mode ? 0 : $urandom_range(0, 15);
        if (rx_stall > 0)
        begin
            frame_ready <= 1'b0;
            repeat (rx_stall) @(posedge clk);
        end
        frame_ready <= 1'b1;
        do
        begin
            @(negedge clk);
            rx_took = frame_valid && frame_ready;
            @(posedge clk);
        end
        while (!rx_took);
    end

    always @(negedge clk)
    begin
        if (rst_n && frame_valid && frame_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("out_byte: none expected, actual %02h", frame.out_byte);
                fail_count++;
            end
            else
            begin
                oldest_byte = expected_bytes.pop_front();
                if (frame.out_byte !== oldest_byte.out_byte)
                begin
                    $error("out_byte: expected %02h, actual %02h",
                           oldest_byte.out_byte, frame.out_byte);
                    fail_count++;
                end
                if (frame.run_last !== oldest_byte.run_last)
                begin
                    $error("run_last: expected %0b, actual %0b",
                           oldest_byte.run_last, frame.run_last);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((info_valid && info_ready) || (frame_valid && frame_ready) || (psel && penable))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        fail_count    = 0;
        quiet_cycles  = 0;
        burst_mode    = 1'b0;
        pause_pending = 1'b0;
        dest_copy     = ax25_pkg::DEST_RESET;
        src_copy      = ax25_pkg::SRC_RESET;
        ctrl_copy     = ax25_pkg::CTRL_RESET;
        pid_copy      = ax25_pkg::PID_RESET;
        running_crc   = ax25_pkg::CRC_PRESET;
        frame_open    = 1'b0;
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        info_valid   <= 1'b0;
        info         <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_corner_cases();
        test_register_extremes();
        test_random_traffic();

        settle();
        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
